// ----- rtl/lcze_pkg.sv -----
// Shared types, codes and the quarter-wave sine builder for the lidar collision zone evaluator.
// Used by every module of the block; depends on nothing.

package lcze_pkg;

	localparam int unsigned NUM_ZONES  = 3;
	localparam int unsigned QSIN_LAST  = 180;	// quarter wave in half-degree steps
	localparam logic [63:0] PI_Q30     = 64'd3373259426;
	localparam logic [10:0] COUNT_MAX  = 11'h7FF;

	// Register map, word index into the APB space
	typedef enum logic [2:0] {
		REG_ENABLE,
		REG_Z1_DEPTH,
		REG_Z1_HALF,
		REG_Z2_DEPTH,
		REG_Z2_HALF,
		REG_Z3_DEPTH,
		REG_Z3_HALF,
		REG_THRESHOLD
	} cfg_reg_t;

	typedef enum logic [1:0] {
		LVL_CLEAR,
		LVL_INNER,
		LVL_MIDDLE,
		LVL_OUTER
	} alarm_level_t;

	// Per-item control travelling down the pipeline
	typedef struct packed {
		logic count_en;	// point is counted (evaluated scan, enabled, in window)
		logic last;	// last point of a scan
		logic gen;	// a result is due on this item
	} item_ctl_t;

	typedef struct packed {
		logic [NUM_ZONES-1:0][15:0] depth;
		logic [NUM_ZONES-1:0][15:0] half;
	} zone_cfg_t;

	// Sine of k half-degrees, k in 0..180, Q15 saturated to 32767.
	// Taylor series in Q30 with truncating steps; evaluated at elaboration only.
	function automatic logic [14:0] quarter_sin(input int unsigned k);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] q;
		longint      sum;
		int          n;
		x    = (64'(k) * PI_Q30 + 64'd180) / 64'd360;
		x2   = (x * x) >> 30;
		term = x;
		sum  = longint'(x);
		for (n = 1; n <= 8; n++) begin
			term = (term * x2) >> 30;
			case (n)
				1: begin
					term = term / 64'd6;
				end
				2: begin
					term = term / 64'd20;
				end
				3: begin
					term = term / 64'd42;
				end
				4: begin
					term = term / 64'd72;
				end
				5: begin
					term = term / 64'd110;
				end
				6: begin
					term = term / 64'd156;
				end
				7: begin
					term = term / 64'd210;
				end
				default: begin
					term = term / 64'd272;
				end
			endcase
			if (n % 2 == 1) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		q = (64'(sum) + 64'd16384) >> 15;
		if (q > 64'd32767) begin
			q = 64'd32767;
		end
		return q[14:0];
	endfunction

endpackage

// ----- rtl/lcze_polar_xy.sv -----
// Beam angle lookup and range products: turns a beam index and range into
// sin*range and cos*range in Q15 mm. Depends on lcze_pkg.

module lcze_polar_xy (
	input  logic                    clk,
	input  logic                    ld,
	input  logic [9:0]              idx_s1,
	input  logic [15:0]             range_s1,
	input  lcze_pkg::item_ctl_t     ctl_s1,
	output logic signed [32:0]      sr_s2,
	output logic signed [32:0]      cr_s2,
	output lcze_pkg::item_ctl_t     ctl_s2
);

	logic [14:0]        qsin [0:lcze_pkg::QSIN_LAST];
	logic [9:0]         t_ang;
	logic [9:0]         u_ang;
	logic [8:0]         sin_fold;
	logic [8:0]         cos_fold;
	logic signed [15:0] sin_v;
	logic signed [15:0] cos_v;
	logic signed [16:0] rng_v;
	logic signed [32:0] sr_next;
	logic signed [32:0] cr_next;

	// Constant quarter-wave table
	for (genvar k = 0; k <= lcze_pkg::QSIN_LAST; k++) begin : g_qsin
		localparam logic [14:0] QVAL = lcze_pkg::quarter_sin(k);
		assign qsin[k] = QVAL;
	end

	// Fold an angle of 0..719 half-degrees onto the quarter wave: {negative, k}
	function automatic logic [8:0] fold(input logic [9:0] a);
		logic [7:0] k;
		logic       neg;
		if (a <= 10'd180) begin
			k   = a[7:0];
			neg = 1'b0;
		end else if (a <= 10'd360) begin
			k   = 8'(10'd360 - a);
			neg = 1'b0;
		end else if (a <= 10'd540) begin
			k   = 8'(a - 10'd360);
			neg = 1'b1;
		end else begin
			k   = 8'(10'd720 - a);
			neg = 1'b1;
		end
		return {neg, k};
	endfunction

	always_comb begin
		// theta = 45 deg - index/2, as (90 - index) mod 720 half-degrees
		if (idx_s1 <= 10'd90) begin
			t_ang = 10'd90 - idx_s1;
		end else if (idx_s1 <= 10'd810) begin
			t_ang = 10'd810 - idx_s1;
		end else begin
			t_ang = 10'(11'd1530 - {1'b0, idx_s1});
		end
		u_ang    = (t_ang >= 10'd540) ? (t_ang - 10'd540) : (t_ang + 10'd180);
		sin_fold = fold(t_ang);
		cos_fold = fold(u_ang);
		sin_v    = sin_fold[8] ? -$signed({1'b0, qsin[sin_fold[7:0]]})
		                       : $signed({1'b0, qsin[sin_fold[7:0]]});
		cos_v    = cos_fold[8] ? -$signed({1'b0, qsin[cos_fold[7:0]]})
		                       : $signed({1'b0, qsin[cos_fold[7:0]]});
		rng_v    = $signed({1'b0, range_s1});
		sr_next  = sin_v * rng_v;
		cr_next  = cos_v * rng_v;
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			sr_s2  <= sr_next;
			cr_s2  <= cr_next;
			ctl_s2 <= ctl_s1;
		end
	end

endmodule

// ----- rtl/lcze_zone_test.sv -----
// Rectangle tests for the three zones on one point's Q15 coordinates.
// Depends on lcze_pkg.

module lcze_zone_test (
	input  logic                              clk,
	input  logic                              ld,
	input  logic signed [32:0]                sr_s2,
	input  logic signed [32:0]                cr_s2,
	input  lcze_pkg::item_ctl_t               ctl_s2,
	input  lcze_pkg::zone_cfg_t               zcfg,
	output logic [lcze_pkg::NUM_ZONES-1:0]    hit_s3,
	output lcze_pkg::item_ctl_t               ctl_s3
);

	logic signed [32:0]                 dq [lcze_pkg::NUM_ZONES];
	logic signed [32:0]                 hq [lcze_pkg::NUM_ZONES];
	logic [lcze_pkg::NUM_ZONES-1:0]     hit_next;

	// x = -sin*range, so 0 < x < depth becomes -depth < sin*range < 0
	always_comb begin
		for (int z = 0; z < lcze_pkg::NUM_ZONES; z++) begin
			dq[z]       = $signed({2'b00, zcfg.depth[z], 15'd0});
			hq[z]       = $signed({2'b00, zcfg.half[z], 15'd0});
			hit_next[z] = ctl_s2.count_en && (sr_s2 < 33'sd0) && (sr_s2 > -dq[z])
			              && (cr_s2 < hq[z]) && (cr_s2 > -hq[z]);
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			hit_s3 <= hit_next;
			ctl_s3 <= ctl_s2;
		end
	end

endmodule

// ----- rtl/lcze_hit_count.sv -----
// Saturating zone counters, level priority and the result register.
// Depends on lcze_pkg.

module lcze_hit_count (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              v3,
	input  lcze_pkg::item_ctl_t               ctl_s3,
	input  logic [lcze_pkg::NUM_ZONES-1:0]    hit_s3,
	input  logic [10:0]                       threshold,
	input  logic                              out_tready,
	output logic                              ready3,
	output logic                              out_tvalid,
	output logic [1:0]                        alarm_level,
	output logic                              level_changed,
	output logic [10:0]                       zone1_count,
	output logic [10:0]                       zone2_count,
	output logic [10:0]                       zone3_count
);

	logic [10:0]            cnt_q  [lcze_pkg::NUM_ZONES];
	logic [10:0]            cnt_nx [lcze_pkg::NUM_ZONES];
	lcze_pkg::alarm_level_t cur_q;
	lcze_pkg::alarm_level_t lvl;
	logic                   out_ready;
	logic                   fire3;
	logic                   load_out;

	assign out_ready = !out_tvalid || out_tready;
	assign ready3    = !v3 || !ctl_s3.gen || out_ready;
	assign fire3     = v3 && ready3;
	assign load_out  = v3 && ctl_s3.gen && out_ready;

	always_comb begin
		for (int z = 0; z < lcze_pkg::NUM_ZONES; z++) begin
			cnt_nx[z] = (hit_s3[z] && cnt_q[z] != lcze_pkg::COUNT_MAX) ? cnt_q[z] + 11'd1
			                                                           : cnt_q[z];
		end
		if (cnt_nx[0] > threshold) begin
			lvl = lcze_pkg::LVL_INNER;
		end else if (cnt_nx[1] > threshold) begin
			lvl = lcze_pkg::LVL_MIDDLE;
		end else if (cnt_nx[2] > threshold) begin
			lvl = lcze_pkg::LVL_OUTER;
		end else begin
			lvl = lcze_pkg::LVL_CLEAR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int z = 0; z < lcze_pkg::NUM_ZONES; z++) begin
				cnt_q[z] <= '0;
			end
			cur_q      <= lcze_pkg::LVL_CLEAR;
			out_tvalid <= 1'b0;
		end else begin
			if (fire3) begin
				for (int z = 0; z < lcze_pkg::NUM_ZONES; z++) begin
					cnt_q[z] <= ctl_s3.last ? 11'd0 : cnt_nx[z];
				end
			end
			if (load_out) begin
				cur_q <= lvl;
			end
			if (out_ready) begin
				out_tvalid <= v3 && ctl_s3.gen;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			alarm_level   <= lvl;
			level_changed <= (lvl != cur_q);
			zone1_count   <= cnt_nx[0];
			zone2_count   <= cnt_nx[1];
			zone3_count   <= cnt_nx[2];
		end
	end

endmodule

// ----- rtl/lidar_collision_zone_evaluator.sv -----
// Lidar collision zone evaluator, top level: stream ports, APB register file,
// scan decimation and the pipeline valid chain. Depends on lcze_pkg and the lcze_* modules.
//
// Use:
//   Points enter on the s_* stream, one transaction per point: beam index and
//   range in s_tdata, s_tlast on the last point of a scan. One scan in every
//   SCAN_DECIMATION is evaluated; points of other scans are dropped apart from
//   their scan_end mark, which advances the scan phase.
//   At the last point of an evaluated scan, with collision_enable set, one
//   result transaction leaves on m_*: alarm level, a changed flag and the three
//   zone counts including that last point. The counts then clear.
//   Registers are written over APB while no point is in flight.
// Timing:
//   Four register stages: input, products, zone flags, result. After the edge
//   that accepts its last point, a result passes the products, zone flag and
//   result stages. One point can be accepted every cycle unless a result waits
//   on m_*; the rate is set by the single multiplier pair and the counter update.
// Reset and stall:
//   arst_n clears the registers to zero, the scan phase, counters and level.
//   While m_tready is low with a result waiting, bubbles in the pipeline are
//   still filled; s_tready drops only once every stage holds a point.

module lidar_collision_zone_evaluator #(
	parameter int FIRST_INDEX       = 60,
	parameter int LAST_INDEX        = 480,
	parameter int SCAN_DECIMATION   = 5,
	parameter int ANGLE_TABLE_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,	// [9:0] beam_index, [25:10] range_mm, rest zero
	input  logic        s_tlast,	// scan_end
	// Result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,	// [1:0] alarm_level, [2] level_changed,
					// [13:3] zone1_count, [24:14] zone2_count,
					// [35:25] zone3_count, rest zero
	// Configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int          PHASE_W    = (SCAN_DECIMATION > 1) ? $clog2(SCAN_DECIMATION) : 1;
	localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(SCAN_DECIMATION - 1);
	localparam logic [12:0] FIRST_L    = 13'(FIRST_INDEX);
	localparam logic [12:0] LAST_L     = 13'(LAST_INDEX);
	localparam logic [12:0] DEPTH_L    = 13'(ANGLE_TABLE_DEPTH);

	// Registers
	logic        enable_q;
	logic [15:0] depth_q [lcze_pkg::NUM_ZONES];
	logic [15:0] half_q  [lcze_pkg::NUM_ZONES];
	logic [10:0] thr_q;
	lcze_pkg::cfg_reg_t  reg_sel;
	lcze_pkg::zone_cfg_t zcfg;
	logic        cfg_wr;

	// Pipeline
	logic [PHASE_W-1:0]    phase_q;
	logic                  accept;
	logic                  eval_in;
	logic                  in_window;
	logic [9:0]            idx_in;
	logic [15:0]           range_in;
	logic [9:0]            idx_s1;
	logic [15:0]           range_s1;
	lcze_pkg::item_ctl_t   ctl_in;
	lcze_pkg::item_ctl_t   ctl_s1;
	lcze_pkg::item_ctl_t   ctl_s2;
	lcze_pkg::item_ctl_t   ctl_s3;
	logic signed [32:0]    sr_s2;
	logic signed [32:0]    cr_s2;
	logic [lcze_pkg::NUM_ZONES-1:0] hit_s3;
	logic                  v1_q;
	logic                  v2_q;
	logic                  v3_q;
	logic                  ready1;
	logic                  ready2;
	logic                  ready3;
	logic [1:0]            alarm_level;
	logic                  level_changed;
	logic [10:0]           zone1_count;
	logic [10:0]           zone2_count;
	logic [10:0]           zone3_count;

	// ---------------------------------------------------------------- APB
	assign pready  = 1'b1;
	assign reg_sel = lcze_pkg::cfg_reg_t'(paddr[4:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			thr_q    <= '0;
			for (int z = 0; z < lcze_pkg::NUM_ZONES; z++) begin
				depth_q[z] <= '0;
				half_q[z]  <= '0;
			end
		end else if (cfg_wr) begin
			case (reg_sel)
				lcze_pkg::REG_ENABLE: begin
					enable_q <= pwdata[0];
				end
				lcze_pkg::REG_Z1_DEPTH: begin
					depth_q[0] <= pwdata[15:0];
				end
				lcze_pkg::REG_Z1_HALF: begin
					half_q[0] <= pwdata[15:0];
				end
				lcze_pkg::REG_Z2_DEPTH: begin
					depth_q[1] <= pwdata[15:0];
				end
				lcze_pkg::REG_Z2_HALF: begin
					half_q[1] <= pwdata[15:0];
				end
				lcze_pkg::REG_Z3_DEPTH: begin
					depth_q[2] <= pwdata[15:0];
				end
				lcze_pkg::REG_Z3_HALF: begin
					half_q[2] <= pwdata[15:0];
				end
				lcze_pkg::REG_THRESHOLD: begin
					thr_q <= pwdata[10:0];
				end
				default: begin
					thr_q <= thr_q;
				end
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			lcze_pkg::REG_ENABLE:    prdata = {31'd0, enable_q};
			lcze_pkg::REG_Z1_DEPTH:  prdata = {16'd0, depth_q[0]};
			lcze_pkg::REG_Z1_HALF:   prdata = {16'd0, half_q[0]};
			lcze_pkg::REG_Z2_DEPTH:  prdata = {16'd0, depth_q[1]};
			lcze_pkg::REG_Z2_HALF:   prdata = {16'd0, half_q[1]};
			lcze_pkg::REG_Z3_DEPTH:  prdata = {16'd0, depth_q[2]};
			lcze_pkg::REG_Z3_HALF:   prdata = {16'd0, half_q[2]};
			lcze_pkg::REG_THRESHOLD: prdata = {21'd0, thr_q};
			default:                 prdata = '0;
		endcase
	end

	always_comb begin
		for (int z = 0; z < lcze_pkg::NUM_ZONES; z++) begin
			zcfg.depth[z] = depth_q[z];
			zcfg.half[z]  = half_q[z];
		end
	end

	// ---------------------------------------------------------------- intake
	// A stage loads when it is empty or its content moves on this cycle.
	assign ready2   = !v2_q || ready3;
	assign ready1   = !v1_q || ready2;
	assign s_tready = ready1;
	assign accept   = s_tvalid && s_tready;

	assign idx_in    = s_tdata[9:0];
	assign range_in  = s_tdata[25:10];
	assign eval_in   = (phase_q >= PHASE_LAST);
	assign in_window = ({3'd0, idx_in} >= FIRST_L) && ({3'd0, idx_in} <= LAST_L)
	                   && ({3'd0, idx_in} < DEPTH_L);

	always_comb begin
		ctl_in.count_en = eval_in && enable_q && in_window;
		ctl_in.last     = s_tlast;
		ctl_in.gen      = s_tlast && eval_in && enable_q;
	end

	// Scan phase: advance on each scan end, wrap after an evaluated scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (accept && s_tlast) begin
			phase_q <= eval_in ? '0 : phase_q + PHASE_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else begin
			if (ready1) begin
				v1_q <= s_tvalid;
			end
			if (ready2) begin
				v2_q <= v1_q;
			end
			if (ready3) begin
				v3_q <= v2_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready1) begin
			idx_s1   <= idx_in;
			range_s1 <= range_in;
			ctl_s1   <= ctl_in;
		end
	end

	// ---------------------------------------------------------------- datapath
	lcze_polar_xy u_polar (
		.clk      (clk),
		.ld       (ready2),
		.idx_s1   (idx_s1),
		.range_s1 (range_s1),
		.ctl_s1   (ctl_s1),
		.sr_s2    (sr_s2),
		.cr_s2    (cr_s2),
		.ctl_s2   (ctl_s2)
	);

	lcze_zone_test u_zone (
		.clk    (clk),
		.ld     (ready3),
		.sr_s2  (sr_s2),
		.cr_s2  (cr_s2),
		.ctl_s2 (ctl_s2),
		.zcfg   (zcfg),
		.hit_s3 (hit_s3),
		.ctl_s3 (ctl_s3)
	);

	lcze_hit_count u_count (
		.clk           (clk),
		.arst_n        (arst_n),
		.v3            (v3_q),
		.ctl_s3        (ctl_s3),
		.hit_s3        (hit_s3),
		.threshold     (thr_q),
		.out_tready    (m_tready),
		.ready3        (ready3),
		.out_tvalid    (m_tvalid),
		.alarm_level   (alarm_level),
		.level_changed (level_changed),
		.zone1_count   (zone1_count),
		.zone2_count   (zone2_count),
		.zone3_count   (zone3_count)
	);

	assign m_tdata = {4'd0, zone3_count, zone2_count, zone1_count, level_changed, alarm_level};

	// ---------------------------------------------------------------- checks
	// Phase never passes the evaluated-scan mark
	a_phase_range : assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= PHASE_LAST)
		else $error("scan phase out of range");

	// Intake blocks only when every stage behind it is full
	a_no_bubble_stall : assert property (@(posedge clk) disable iff (!arst_n)
		(v1_q && !s_tready) |-> (v2_q && v3_q))
		else $error("intake stalled with a bubble in the pipeline");

	// A result waiting behind a blocked output stays in the counter stage
	a_hold_result : assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready && v3_q && ctl_s3.gen) |=> (v3_q && ctl_s3.gen))
		else $error("pending result lost during output stall");

endmodule

// ----- test/tb_lidar_collision_zone_evaluator.sv -----
`timescale 1ns / 100ps
// Testbench for lidar_collision_zone_evaluator: streams range points in, programs the zones
// over APB and checks every zone report against a bit-exact predictor. Depends on lcze_pkg
// and the RTL of the block.

module tb_lidar_collision_zone_evaluator;

	localparam int FIRST_BEAM      = 60;
	localparam int LAST_BEAM       = 480;
	localparam int EVAL_EVERY      = 5;
	localparam int TABLE_DEPTH     = 1024;
	localparam int SETTLE_CYCLES   = 8;	// pipeline is four stages deep
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int LONG_SCAN       = 240;	// one evaluated scan, well past the threshold
	localparam int RANDOM_BUDGET   = 50;	// points per register setting
	localparam int CYCLE_LIMIT     = 200000;

	typedef longint unsigned u64_t;

	// One zone report as it leaves on the result stream
	typedef struct packed {
		lcze_pkg::alarm_level_t level;
		logic                   changed;
		logic [2:0][10:0]       count;	// count[0] is the innermost zone
	} zone_report_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;	// [9:0] beam_index, [25:10] range_mm, rest zero
	logic        s_tlast  = 1'b0;	// scan_end
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;		// [1:0] alarm_level, [2] level_changed, [13:3] zone1_count,
					// [24:14] zone2_count, [35:25] zone3_count, rest zero
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [4:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	// Predictor state: angle table, register copies, scan phase, counters and level
	int                     sin_tab [TABLE_DEPTH];
	int                     cos_tab [TABLE_DEPTH];
	bit                     cfg_enable;
	bit [15:0]              cfg_depth [3];
	bit [15:0]              cfg_half [3];
	bit [10:0]              cfg_threshold;
	int unsigned            scan_phase;
	bit [10:0]              zone_hits [3];
	lcze_pkg::alarm_level_t held_level = lcze_pkg::LVL_CLEAR;
	zone_report_t           pending_reports [$];

	int error_count;
	int points_sent;
	int reports_checked;
	int cycle_count;
	int stall_left;
	bit tx_idling;
	bit rx_idling;
	bit hold_request;

	lidar_collision_zone_evaluator #(
		.FIRST_INDEX      (FIRST_BEAM),
		.LAST_INDEX       (LAST_BEAM),
		.SCAN_DECIMATION  (EVAL_EVERY),
		.ANGLE_TABLE_DEPTH(TABLE_DEPTH)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------- predictor

	// Sine of k half-degrees (k in 0..180) in Q15: Taylor series in Q30, each step
	// truncated, rounded half up at the end and saturated so that 1.0 reads 32767.
	function automatic int quarter_wave_q15(int unsigned k);
		u64_t   ang;
		u64_t   ang_sq;
		u64_t   term;
		u64_t   rounded;
		longint acc;
		int     n;
		ang    = (u64_t'(k) * 64'd3373259426 + 64'd180) / 64'd360;
		ang_sq = (ang * ang) >> 30;
		term   = ang;
		acc    = longint'(ang);
		for (n = 1; n <= 8; n++) begin
			term = ((term * ang_sq) >> 30) / u64_t'((2 * n) * (2 * n + 1));
			if (n % 2 == 1) begin
				acc = acc - longint'(term);
			end else begin
				acc = acc + longint'(term);
			end
		end
		if (acc < 0) begin
			acc = 0;
		end
		rounded = (u64_t'(acc) + 64'd16384) >> 15;
		return (rounded > 64'd32767) ? 32767 : int'(rounded);
	endfunction

	// Full wave from the quarter wave, t in half-degrees 0..719
	function automatic int wave_q15(int unsigned t);
		if (t <= 180) begin
			return quarter_wave_q15(t);
		end
		if (t <= 360) begin
			return quarter_wave_q15(360 - t);
		end
		if (t <= 540) begin
			return -quarter_wave_q15(t - 360);
		end
		return -quarter_wave_q15(720 - t);
	endfunction

	// theta = 45 - index/2 degrees, folded into one turn of half-degree steps
	function automatic void build_angle_table();
		int unsigned t;
		int          i;
		for (i = 0; i < TABLE_DEPTH; i++) begin
			t          = (90 + 5760 - (i % 5760)) % 720;
			sin_tab[i] = wave_q15(t);
			cos_tab[i] = wave_q15((t + 180) % 720);
		end
	endfunction

	// Strictly inside the rectangle; x and y stay in Q15 mm, nothing is rounded
	function automatic bit zone_contains(longint xq, longint yq, int z);
		longint lim_x;
		longint lim_y;
		lim_x = longint'(cfg_depth[z]) * 32768;
		lim_y = longint'(cfg_half[z]) * 32768;
		return xq > 0 && xq < lim_x && yq < lim_y && yq > -lim_y;
	endfunction

	// Advance the model by one accepted point; queue a report when one is due
	function automatic void track_point(bit [9:0] beam, bit [15:0] rng, bit last);
		bit           evaluated;
		longint       xq;
		longint       yq;
		int           z;
		zone_report_t rep;
		evaluated = (scan_phase + 1 >= EVAL_EVERY);
		if (evaluated && cfg_enable && beam >= FIRST_BEAM && beam <= LAST_BEAM &&
				beam < TABLE_DEPTH) begin
			xq = -(longint'(sin_tab[beam]) * longint'(rng));
			yq = longint'(cos_tab[beam]) * longint'(rng);
			for (z = 0; z < 3; z++) begin
				if (zone_contains(xq, yq, z) && zone_hits[z] != lcze_pkg::COUNT_MAX) begin
					zone_hits[z]++;
				end
			end
		end
		if (last) begin
			if (evaluated) begin
				if (cfg_enable) begin
					// innermost zone wins
					if (zone_hits[0] > cfg_threshold) begin
						rep.level = lcze_pkg::LVL_INNER;
					end else if (zone_hits[1] > cfg_threshold) begin
						rep.level = lcze_pkg::LVL_MIDDLE;
					end else if (zone_hits[2] > cfg_threshold) begin
						rep.level = lcze_pkg::LVL_OUTER;
					end else begin
						rep.level = lcze_pkg::LVL_CLEAR;
					end
					rep.changed = (rep.level != held_level);
					for (z = 0; z < 3; z++) begin
						rep.count[z] = zone_hits[z];
					end
					held_level = rep.level;
					pending_reports.push_back(rep);
				end
				scan_phase = 0;
			end else begin
				scan_phase = (scan_phase + 1) & 15;
			end
			for (z = 0; z < 3; z++) begin
				zone_hits[z] = '0;
			end
		end
	endfunction

	function automatic void apply_register(lcze_pkg::cfg_reg_t reg_id, bit [31:0] value);
		case (reg_id)
			lcze_pkg::REG_ENABLE:    cfg_enable    = value[0];
			lcze_pkg::REG_Z1_DEPTH:  cfg_depth[0]  = value[15:0];
			lcze_pkg::REG_Z1_HALF:   cfg_half[0]   = value[15:0];
			lcze_pkg::REG_Z2_DEPTH:  cfg_depth[1]  = value[15:0];
			lcze_pkg::REG_Z2_HALF:   cfg_half[1]   = value[15:0];
			lcze_pkg::REG_Z3_DEPTH:  cfg_depth[2]  = value[15:0];
			lcze_pkg::REG_Z3_HALF:   cfg_half[2]   = value[15:0];
			lcze_pkg::REG_THRESHOLD: cfg_threshold = value[10:0];
			default: begin
			end
		endcase
	endfunction

	// ---------------------------------------------------------------- drivers

	// APB write: setup cycle, then access cycle until pready; mirror into the predictor
	task automatic write_register(lcze_pkg::cfg_reg_t reg_id, bit [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_id, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		apply_register(reg_id, value);
		@(posedge clk);
	endtask

	task automatic program_zones(bit enable, bit [15:0] d1, bit [15:0] h1, bit [15:0] d2,
			bit [15:0] h2, bit [15:0] d3, bit [15:0] h3, bit [10:0] thr);
		write_register(lcze_pkg::REG_ENABLE, 32'(enable));
		write_register(lcze_pkg::REG_Z1_DEPTH, 32'(d1));
		write_register(lcze_pkg::REG_Z1_HALF, 32'(h1));
		write_register(lcze_pkg::REG_Z2_DEPTH, 32'(d2));
		write_register(lcze_pkg::REG_Z2_HALF, 32'(h2));
		write_register(lcze_pkg::REG_Z3_DEPTH, 32'(d3));
		write_register(lcze_pkg::REG_Z3_HALF, 32'(h3));
		write_register(lcze_pkg::REG_THRESHOLD, 32'(thr));
	endtask

	// Offer one point and hold it until the transaction completes. tvalid is left high on
	// return so that a following point goes out back to back; idle gaps lower it first.
	task automatic send_point(bit [9:0] beam, bit [15:0] rng, bit last);
		if (tx_idling && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'd0, rng, beam};
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		track_point(beam, rng, last);
		points_sent++;
	endtask

	// Drop tvalid, let every expected report drain, then let the pipeline empty of
	// points that cause no report, so that the registers may be rewritten.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Beams mostly where x is positive, some across the window, some anywhere
	function automatic bit [9:0] pick_beam();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 6) begin
			return 10'($urandom_range(91, 449));
		end
		if (r < 8) begin
			return 10'($urandom_range(FIRST_BEAM, LAST_BEAM));
		end
		return 10'($urandom_range(0, 1023));
	endfunction

	// Ranges mostly around the programmed zones, the rest over the full field
	function automatic bit [15:0] pick_range();
		int unsigned reach;
		int          z;
		reach = 0;
		for (z = 0; z < 3; z++) begin
			if (cfg_depth[z] > reach) begin
				reach = cfg_depth[z];
			end
		end
		reach = 2 * reach + 1;
		if (reach > 65535) begin
			reach = 65535;
		end
		if ($urandom_range(0, 9) < 6) begin
			return 16'($urandom_range(0, reach));
		end
		return 16'($urandom_range(0, 65535));
	endfunction

	function automatic bit [15:0] pick_extent();
		case ($urandom_range(0, 5))
			0: return 16'd0;
			1: return 16'hFFFF;
			default: return 16'($urandom_range(100, 20000));
		endcase
	endfunction

	function automatic bit [10:0] pick_threshold();
		case ($urandom_range(0, 7))
			0: return 11'd0;
			1: return 11'd1024;
			default: return 11'($urandom_range(0, 3));
		endcase
	endfunction

	task automatic send_scan(int n_points);
		int i;
		for (i = 0; i < n_points; i++) begin
			send_point(pick_beam(), pick_range(), i == n_points - 1);
		end
	endtask

	task automatic send_random_scans(int budget);
		int n;
		while (budget > 0) begin
			n = $urandom_range(1, 8);
			send_scan(n);
			budget -= n;
		end
	endtask

	task automatic program_random_zones();
		program_zones($urandom_range(0, 4) != 0, pick_extent(), pick_extent(),
			pick_extent(), pick_extent(), pick_extent(), pick_extent(), pick_threshold());
	endtask

	// ---------------------------------------------------------------- result side

	// Ready with random stall bursts; a hold-off request parks it for a long stretch
	always @(posedge clk) begin
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else if (hold_request) begin
			m_tready     <= 1'b0;
			stall_left   = HOLD_OFF_CYCLES - 1;
			hold_request = 1'b0;
		end else if (rx_idling && $urandom_range(0, 5) == 0) begin
			m_tready   <= 1'b0;
			stall_left = $urandom_range(0, 11);
		end else begin
			m_tready <= 1'b1;
		end
	end

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			error_count++;
		end
	endfunction

	// Compare each report transaction with the oldest expectation
	always @(posedge clk) begin
		zone_report_t want;
		if (m_tvalid && m_tready) begin
			if (pending_reports.size() == 0) begin
				$display("%0t: unexpected zone report, expected none, actual %h",
					$time, m_tdata);
				error_count++;
			end else begin
				want = pending_reports.pop_front();
				reports_checked++;
				check_field("alarm_level", want.level, m_tdata[1:0]);
				check_field("level_changed", want.changed, m_tdata[2]);
				check_field("zone1_count", want.count[0], m_tdata[13:3]);
				check_field("zone2_count", want.count[1], m_tdata[24:14]);
				check_field("zone3_count", want.count[2], m_tdata[35:25]);
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d reports outstanding", $time,
				pending_reports.size());
			$display("Some tests failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------- tests

	// Edges of the window and the field: ignored scans, indices either side of the window,
	// x exactly zero, range zero and full scale, a point just inside the inner depth,
	// then a disabled evaluated scan that must produce nothing.
	task automatic test_directed_points();
		tx_idling = 1'b1;
		rx_idling = 1'b1;
		program_zones(1'b1, 16'd2000, 16'd1000, 16'd5000, 16'd2500, 16'd20000, 16'd10000,
			11'd0);
		repeat (EVAL_EVERY - 1) send_point(10'd270, 16'd1500, 1'b1);
		send_point(10'd0, 16'd1500, 1'b0);
		send_point(10'(FIRST_BEAM - 1), 16'd1500, 1'b0);
		send_point(10'(FIRST_BEAM), 16'd1500, 1'b0);
		send_point(10'(LAST_BEAM), 16'd1500, 1'b0);
		send_point(10'(LAST_BEAM + 1), 16'd1500, 1'b0);
		send_point(10'd1023, 16'hFFFF, 1'b0);
		send_point(10'd90, 16'd1500, 1'b0);	// beam along y: x is zero
		send_point(10'd270, 16'd1500, 1'b0);	// straight ahead
		send_point(10'd270, 16'd0, 1'b0);
		send_point(10'd270, 16'hFFFF, 1'b0);
		send_point(10'd270, 16'd2000, 1'b0);	// just short of the inner depth
		send_point(10'd180, 16'd3000, 1'b0);
		send_point(10'd360, 16'd10000, 1'b1);
		wait_idle();
		write_register(lcze_pkg::REG_ENABLE, 32'd0);
		repeat (EVAL_EVERY - 1) send_point(10'd270, 16'd1500, 1'b1);
		send_point(10'd270, 16'd1500, 1'b0);
		send_point(10'd270, 16'd1500, 1'b1);
	endtask

	// Several register settings, extremes first, each followed by random scans
	task automatic test_random_scans();
		int phase_no;
		for (phase_no = 0; phase_no < 12; phase_no++) begin
			wait_idle();
			case (phase_no)
				0: program_zones(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
					16'hFFFF, 11'd0);
				1: program_zones(1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 11'd1024);
				2: program_zones(1'b1, 16'd1500, 16'd800, 16'd4000, 16'd2000, 16'd9000,
					16'd5000, 11'd1);
				default: program_random_zones();
			endcase
			tx_idling = $urandom_range(0, 3) != 0;
			rx_idling = $urandom_range(0, 3) != 0;
			send_random_scans(RANDOM_BUDGET);
		end
	endtask

	// Park the result side while points keep coming, so the pipeline fills and stalls
	task automatic test_output_hold_off();
		int i;
		wait_idle();
		program_zones(1'b1, 16'd3000, 16'd1500, 16'd6000, 16'd3000, 16'd12000, 16'd6000,
			11'd0);
		tx_idling    = 1'b0;
		rx_idling    = 1'b0;
		hold_request = 1'b1;
		for (i = 0; i < 30; i++) begin
			send_scan($urandom_range(2, 6));
		end
	endtask

	// One long evaluated scan straight ahead inside every zone: large counts, inner alarm
	task automatic test_long_scan();
		int i;
		wait_idle();
		program_zones(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			11'd200);
		while (scan_phase + 1 < EVAL_EVERY) send_point(10'd0, 16'd0, 1'b1);
		for (i = 0; i < LONG_SCAN; i++) begin
			send_point(10'd270, 16'd1000, i == LONG_SCAN - 1);
		end
	endtask

	// Closing stretch at full rate, no idling on either side
	task automatic test_steady_stream();
		wait_idle();
		tx_idling = 1'b0;
		rx_idling = 1'b0;
		program_zones(1'b1, 16'd2500, 16'd1200, 16'd5000, 16'd2500, 16'd10000, 16'd5000,
			11'd1);
		send_random_scans(130);
	endtask

	initial begin
		build_angle_table();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_points();
		test_random_scans();
		test_output_hold_off();
		test_long_scan();
		test_steady_stream();
		wait_idle();

		$display("Sent %0d points and checked %0d zone reports across %0d register settings,",
			points_sent, reports_checked, 17);
		$display("with idle gaps, a %0d-cycle output hold-off and a long evaluated scan.",
			HOLD_OFF_CYCLES);
		if (error_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/lcze_pkg.sv
rtl/lcze_polar_xy.sv
rtl/lcze_zone_test.sv
rtl/lcze_hit_count.sv
rtl/lidar_collision_zone_evaluator.sv
test/tb_lidar_collision_zone_evaluator.sv
